@@ rtl/core/cbm_pkg.sv @@
// cbm_pkg: shared types and constants for the cartridge bank mapper
// holds word structs, region codes, controller kinds and address limits
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

  localparam int unsigned ROM_BANK_COUNT_DEF = 128;
  localparam int unsigned RAM_BANK_COUNT_DEF = 4;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned PHYS_W   = 21;
  localparam int unsigned ROMBNK_W = 7;
  localparam int unsigned RAMBNK_W = 2;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  // config register byte address of the controller kind register
  localparam logic [PADDR_W-1:0] REG_MBC_KIND = 3'd0;

  // controller kinds
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MBC1 = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MBC2 = 2'd2;

  // access kinds
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef enum logic [2:0] {
    REGION_ROM     = 3'd0,
    REGION_RAM     = 3'd1,
    REGION_FIXED   = 3'd2,
    REGION_BANKREG = 3'd3,
    REGION_DROPPED = 3'd4
  } region_t;

  // bus address limits
  localparam logic [ADDR_W-1:0] ADDR_ROMB_LO = 16'h4000;
  localparam logic [ADDR_W-1:0] ADDR_ROMB_HI = 16'h8000;
  localparam logic [ADDR_W-1:0] ADDR_RAM_LO  = 16'hA000;
  localparam logic [ADDR_W-1:0] ADDR_RAM_HI  = 16'hC000;
  localparam logic [ADDR_W-1:0] ADDR_RSV_LO  = 16'hFEA0;
  localparam logic [ADDR_W-1:0] ADDR_RSV_HI  = 16'hFEFF;

  // ram enable nibble codes
  localparam logic [3:0] RAM_EN_CODE  = 4'hA;
  localparam logic [3:0] RAM_DIS_CODE = 4'h0;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
  } req_word_t;

  typedef struct packed {
    logic [2:0]          region;
    logic [PHYS_W-1:0]   physical_address;
    logic [ROMBNK_W-1:0] rom_bank_now;
    logic [RAMBNK_W-1:0] ram_bank_now;
  } rsp_word_t;

  typedef struct packed {
    logic [ROMBNK_W-1:0] rom_bank;
    logic [RAMBNK_W-1:0] ram_bank;
    logic                ram_enabled;
    logic                rom_banking_mode;
  } bank_state_t;

endpackage

`default_nettype wire

@@ rtl/core/cbm_bank_regs.sv @@
// cbm_bank_regs: bank register file of the mapper and its write decode
// depends on cbm_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbm_bank_regs
  import cbm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              update,
  input  wire req_word_t         word,
  input  wire logic [KIND_W-1:0] kind,
  output bank_state_t            state,
  output bank_state_t            state_next
);

  bank_state_t regs;
  logic        mbc1;
  logic        mbc2;
  logic        bank_wr;
  logic [3:0]  nib;
  logic        rom_chg;
  logic [ROMBNK_W-1:0] rom_raw;

  assign mbc1    = (kind == KIND_MBC1);
  assign mbc2    = (kind == KIND_MBC2);
  assign bank_wr = (word.action == ACT_WRITE) && (word.address < ADDR_ROMB_HI);
  assign nib     = word.data[3:0];

  always_comb begin
    state_next = regs;
    rom_chg    = 1'b0;
    rom_raw    = regs.rom_bank;
    if (bank_wr) begin
      unique case (word.address[14:13])
        2'd0: begin
          // ram enable, mbc2 ignores writes with address bit 8 set
          if (mbc1 || (mbc2 && !word.address[8])) begin
            if (nib == RAM_EN_CODE) begin
              state_next.ram_enabled = 1'b1;
            end else if (nib == RAM_DIS_CODE) begin
              state_next.ram_enabled = 1'b0;
            end
          end
        end
        2'd1: begin
          if (mbc2) begin
            rom_raw = {3'b000, word.data[3:0]};
            rom_chg = 1'b1;
          end else if (mbc1) begin
            rom_raw = {regs.rom_bank[6:5], word.data[4:0]};
            rom_chg = 1'b1;
          end
        end
        2'd2: begin
          if (mbc1) begin
            if (regs.rom_banking_mode) begin
              rom_raw = {word.data[1:0], regs.rom_bank[4:0]};
              rom_chg = 1'b1;
            end else begin
              state_next.ram_bank = word.data[1:0];
            end
          end
        end
        default: begin
          if (mbc1) begin
            state_next.rom_banking_mode = !word.data[0];
            if (!word.data[0]) begin
              state_next.ram_bank = '0;
            end
          end
        end
      endcase
    end
    // bank zero maps to bank one
    if (rom_chg) begin
      state_next.rom_bank = (rom_raw == '0) ? ROMBNK_W'(1) : rom_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.rom_bank         <= ROMBNK_W'(1);
      regs.ram_bank         <= '0;
      regs.ram_enabled      <= 1'b0;
      regs.rom_banking_mode <= 1'b1;
    end else if (update) begin
      regs <= state_next;
    end
  end

  assign state = regs;

endmodule

`default_nettype wire

@@ rtl/core/cbm_translate.sv @@
// cbm_translate: maps one bus access to a region and physical offset
// depends on cbm_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbm_translate
  import cbm_pkg::*;
#(
  parameter int unsigned ROM_BANK_COUNT = ROM_BANK_COUNT_DEF,
  parameter int unsigned RAM_BANK_COUNT = RAM_BANK_COUNT_DEF
) (
  input  wire req_word_t   word,
  input  wire bank_state_t state,
  output region_t          region,
  output logic [PHYS_W-1:0] phys
);

  localparam int unsigned ROM_SEL_W = (ROM_BANK_COUNT > 1) ? $clog2(ROM_BANK_COUNT) : 1;
  localparam int unsigned RAM_SEL_W = (RAM_BANK_COUNT > 1) ? $clog2(RAM_BANK_COUNT) : 1;
  localparam int unsigned ROM_TBL_N = 2 ** ROMBNK_W;
  localparam int unsigned RAM_TBL_N = 2 ** RAMBNK_W;

  // bank number folded into the fitted bank count, as constant tables
  logic [ROM_SEL_W-1:0] rom_mod_tbl [ROM_TBL_N];
  logic [RAM_SEL_W-1:0] ram_mod_tbl [RAM_TBL_N];

  for (genvar i = 0; i < ROM_TBL_N; i++) begin : g_rom_tbl
    assign rom_mod_tbl[i] = ROM_SEL_W'(i % ROM_BANK_COUNT);
  end
  for (genvar j = 0; j < RAM_TBL_N; j++) begin : g_ram_tbl
    assign ram_mod_tbl[j] = RAM_SEL_W'(j % RAM_BANK_COUNT);
  end

  logic [ROM_SEL_W-1:0] rom_sel;
  logic [RAM_SEL_W-1:0] ram_sel;
  logic [PHYS_W-1:0]    rom_off;
  logic [PHYS_W-1:0]    ram_off;
  logic [PHYS_W-1:0]    bus_addr;
  logic                 in_romb;
  logic                 in_ram;
  logic                 in_rsv;

  assign rom_sel  = rom_mod_tbl[state.rom_bank];
  assign ram_sel  = ram_mod_tbl[state.ram_bank];
  assign rom_off  = PHYS_W'({rom_sel, word.address[13:0]});
  assign ram_off  = PHYS_W'({ram_sel, word.address[12:0]});
  assign bus_addr = PHYS_W'(word.address);

  assign in_romb = (word.address >= ADDR_ROMB_LO) && (word.address < ADDR_ROMB_HI);
  assign in_ram  = (word.address >= ADDR_RAM_LO) && (word.address < ADDR_RAM_HI);
  assign in_rsv  = (word.address >= ADDR_RSV_LO) && (word.address < ADDR_RSV_HI);

  always_comb begin
    region = REGION_FIXED;
    phys   = bus_addr;
    if (word.action == ACT_WRITE) begin
      if (word.address < ADDR_ROMB_HI) begin
        region = REGION_BANKREG;
      end else if (in_ram) begin
        if (state.ram_enabled) begin
          region = REGION_RAM;
          phys   = ram_off;
        end else begin
          region = REGION_DROPPED;
          phys   = '0;
        end
      end else if (in_rsv) begin
        region = REGION_DROPPED;
        phys   = '0;
      end
    end else begin
      if (in_romb) begin
        region = REGION_ROM;
        phys   = rom_off;
      end else if (in_ram) begin
        region = REGION_RAM;
        phys   = ram_off;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cartridge_bank_mapper_unit.sv @@
// cartridge_bank_mapper_unit: top level of the cartridge bank mapper
// depends on cbm_pkg, cbm_bank_regs and cbm_translate
`timescale 1ns / 1ps
`default_nettype none

// Translates one cpu bus access word per clock, while not stalled, into a
// target region and a physical rom or ram offset, the way an mbc1 or mbc2
// cartridge controller would. Request words enter an input register; as a
// word moves on, short logic decodes the access, updates the bank registers
// for writes below 0x8000 and loads the response register; a new word is
// taken every cycle while the response side keeps up. The response
// register decouples the two sides: a stalled response still lets the
// input register fill. rom_bank_now and ram_bank_now report the banks
// after the access. The controller kind lives in the single config
// register at byte address 0 (0 none, 1 mbc1, 2 mbc2, 3 behaves as none)
// and should be written only while idle. There is no memory and no
// clearing pass; bank registers come out of reset at rom bank 1, ram bank
// 0, ram disabled, rom banking mode.
module cartridge_bank_mapper_unit
  import cbm_pkg::*;
#(
  parameter int unsigned ROM_BANK_COUNT = ROM_BANK_COUNT_DEF,
  parameter int unsigned RAM_BANK_COUNT = RAM_BANK_COUNT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // request channel
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire req_word_t          req,
  // response channel
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output rsp_word_t               rsp,
  // config port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  // config register
  logic [KIND_W-1:0] mbc_kind;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mbc_kind <= KIND_NONE;
    end else if (cfg_wr && (paddr == REG_MBC_KIND)) begin
      mbc_kind <= pwdata[KIND_W-1:0];
    end
  end

  // only register 0 exists, everything else reads as zero
  assign prdata = (paddr == REG_MBC_KIND) ? PDATA_W'(mbc_kind) : '0;

  // input register
  logic      in_valid;
  req_word_t in_word;
  logic      advance;
  logic      req_take;

  // input word moves on when the response register is empty or draining
  assign advance   = in_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = in_valid && !advance;
  assign req_take  = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req_take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      in_word <= req;
    end
  end

  // bank registers, updated as the word moves to the response register
  bank_state_t bank_cur;
  bank_state_t bank_next;

  cbm_bank_regs u_bank_regs (
    .clk        (clk),
    .rst        (rst),
    .update     (advance),
    .word       (in_word),
    .kind       (mbc_kind),
    .state      (bank_cur),
    .state_next (bank_next)
  );

  // address translation uses the banks as they stand before this word
  region_t           xl_region;
  logic [PHYS_W-1:0] xl_phys;

  cbm_translate #(
    .ROM_BANK_COUNT (ROM_BANK_COUNT),
    .RAM_BANK_COUNT (RAM_BANK_COUNT)
  ) u_translate (
    .word   (in_word),
    .state  (bank_cur),
    .region (xl_region),
    .phys   (xl_phys)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.region           <= xl_region;
      rsp.physical_address <= xl_phys;
      rsp.rom_bank_now     <= bank_next.rom_bank;
      rsp.ram_bank_now     <= bank_next.ram_bank;
    end
  end

endmodule

`default_nettype wire
